### rtl/kwsc_pkg.sv
`default_nettype none

package kwsc_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int IDX_W  = 5;
    localparam int CNT_W  = 5;
    localparam int CHAR_W = 8;
    localparam int ACT_W  = 3;
    localparam int STAT_W = 2;
    localparam int IN_W   = 16;
    localparam int OUT_W  = 16;
    localparam int OUT_PAD = OUT_W - CHAR_W - STAT_W;

    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(ALPHABET_SIZE - 1);
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

    typedef enum logic [ACT_W-1:0] {
        ACT_START   = 3'd0,
        ACT_LETTER  = 3'd1,
        ACT_FINISH  = 3'd2,
        ACT_ENCRYPT = 3'd3,
        ACT_DECRYPT = 3'd4
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_KEY   = 2'd1,
        STAT_NOT_READY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_WALK = 3'b100
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;       // input beat accepted
        logic direct;     // load result straight from the accepted beat
        logic look_done;  // load result from the table read
        logic walk_go;    // one step of the fill walk
        logic walk_end;   // last walk step, load result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_look;
        logic need_walk;
        logic walk_last;
        logic key_ready;
    } t_stat;

endpackage

`default_nettype wire

### rtl/kwsc_ctrl.sv
`default_nettype none

module kwsc_ctrl import kwsc_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_s_tvalid,
    output logic  o_s_tready,
    output logic  o_m_tvalid,
    input  wire   i_m_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   load;

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                // output slot must be free or draining this cycle
                o_s_tready = !r_out_valid || i_m_tready;
                o_cmd.take = i_s_tvalid && o_s_tready;
                if (o_cmd.take) begin
                    if (i_stat.need_look) begin
                        n_state = S_LOOK;
                    end else if (i_stat.need_walk) begin
                        n_state = S_WALK;
                    end else begin
                        o_cmd.direct = 1'b1;
                    end
                end
            end
            S_LOOK: begin
                o_cmd.look_done = 1'b1;
                n_state = S_IDLE;
            end
            S_WALK: begin
                o_cmd.walk_go = 1'b1;
                if (i_stat.walk_last) begin
                    o_cmd.walk_end = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign load = o_cmd.direct || o_cmd.look_done || o_cmd.walk_end;

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

`default_nettype wire

### rtl/kwsc_dp.sv
`default_nettype none

module kwsc_dp import kwsc_pkg::*; (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire  [IN_W-1:0]  i_s_tdata,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    output logic [OUT_W-1:0] o_m_tdata
);

    logic [IDX_W-1:0] r_fwd [0:ALPHABET_SIZE-1];
    logic [IDX_W-1:0] r_inv [0:ALPHABET_SIZE-1];

    logic [ALPHABET_SIZE-1:0] r_used, n_used;
    logic [CNT_W-1:0]         r_fill, n_fill;
    logic                     r_ready, n_ready;
    logic                     r_error, n_error;

    logic [IDX_W-1:0]  r_walk;
    logic [CHAR_W-1:0] r_char;
    logic              r_lower;
    logic              r_dec;
    logic [IDX_W-1:0]  r_rd_f;
    logic [IDX_W-1:0]  r_rd_i;
    logic [CHAR_W-1:0] r_out_char;
    t_status           r_out_stat;

    t_action           act;
    logic [CHAR_W-1:0] ch;
    logic              is_up, is_lo, is_let;
    logic [IDX_W-1:0]  idx;
    t_status           d_stat;
    logic              need_look, need_walk;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_let;
    logic [IDX_W-1:0]  wr_pos;
    logic [IDX_W-1:0]  rd_val;
    logic [CHAR_W-1:0] base;

    assign act = t_action'(i_s_tdata[ACT_W-1:0]);
    assign ch  = i_s_tdata[ACT_W +: CHAR_W];

    assign is_up  = (ch >= CH_UPPER_A) && (ch < CH_UPPER_A + CHAR_W'(ALPHABET_SIZE));
    assign is_lo  = (ch >= CH_LOWER_A) && (ch < CH_LOWER_A + CHAR_W'(ALPHABET_SIZE));
    assign is_let = is_up || is_lo;
    assign idx    = is_up ? IDX_W'(ch - CH_UPPER_A) : IDX_W'(ch - CH_LOWER_A);

    // decode of the waiting beat, independent of acceptance
    always_comb begin
        d_stat    = STAT_OK;
        need_look = 1'b0;
        need_walk = 1'b0;
        case (act)
            ACT_LETTER: begin
                if (r_error || (!r_ready && !is_let)) begin
                    d_stat = STAT_BAD_KEY;
                end
            end
            ACT_FINISH: begin
                if (r_error) begin
                    d_stat = STAT_BAD_KEY;
                end else begin
                    need_walk = 1'b1;
                end
            end
            ACT_ENCRYPT, ACT_DECRYPT: begin
                if (!r_ready) begin
                    d_stat = STAT_NOT_READY;
                end else if (is_let) begin
                    need_look = 1'b1;
                end
            end
            default: begin
                d_stat = STAT_OK;
            end
        endcase
    end

    // key state updates; each placed letter writes both tables
    always_comb begin
        n_used  = r_used;
        n_fill  = r_fill;
        n_ready = r_ready;
        n_error = r_error;
        wr_en   = 1'b0;
        wr_let  = idx;
        if (i_cmd.take) begin
            case (act)
                ACT_START: begin
                    n_used  = '0;
                    n_fill  = '0;
                    n_ready = 1'b0;
                    n_error = 1'b0;
                end
                ACT_LETTER: begin
                    if (!r_ready && !r_error) begin
                        if (!is_let) begin
                            n_error = 1'b1;
                        end else if (!r_used[idx] && (r_fill < CNT_W'(ALPHABET_SIZE))) begin
                            n_used[idx] = 1'b1;
                            n_fill      = r_fill + CNT_W'(1);
                            wr_en       = 1'b1;
                        end
                    end
                end
                default: begin
                    n_fill = r_fill;
                end
            endcase
        end else if (i_cmd.walk_go) begin
            wr_let = r_walk;
            if (!r_used[r_walk] && (r_fill < CNT_W'(ALPHABET_SIZE))) begin
                n_used[r_walk] = 1'b1;
                n_fill         = r_fill + CNT_W'(1);
                wr_en          = 1'b1;
            end
            if (i_cmd.walk_end) begin
                n_ready = 1'b1;
            end
        end
    end

    assign wr_pos = IDX_W'(r_fill);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_fwd[wr_pos] <= wr_let;
            r_inv[wr_let] <= wr_pos;
        end
        if (i_cmd.take && need_look) begin
            r_rd_f <= r_fwd[idx];
            r_rd_i <= r_inv[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_fill  <= '0;
            r_ready <= 1'b0;
            r_error <= 1'b0;
        end else begin
            r_used  <= n_used;
            r_fill  <= n_fill;
            r_ready <= n_ready;
            r_error <= n_error;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_char  <= ch;
            r_lower <= is_lo;
            r_dec   <= (act == ACT_DECRYPT);
            r_walk  <= '0;
        end else if (i_cmd.walk_go) begin
            r_walk <= r_walk + IDX_W'(1);
        end
    end

    assign rd_val = r_dec ? r_rd_i : r_rd_f;
    assign base   = r_lower ? CH_LOWER_A : CH_UPPER_A;

    always_ff @(posedge i_clk) begin
        if (i_cmd.direct) begin
            r_out_char <= ch;
            r_out_stat <= d_stat;
        end else if (i_cmd.look_done) begin
            r_out_char <= base + CHAR_W'(rd_val);
            r_out_stat <= STAT_OK;
        end else if (i_cmd.walk_end) begin
            r_out_char <= r_char;
            r_out_stat <= STAT_OK;
        end
    end

    assign o_stat.need_look = need_look;
    assign o_stat.need_walk = need_walk;
    assign o_stat.walk_last = (r_walk == LAST_IDX);
    assign o_stat.key_ready = r_ready;

    assign o_m_tdata = {{OUT_PAD{1'b0}}, STAT_W'(r_out_stat), r_out_char};

endmodule

`default_nettype wire

### rtl/keyword_substitution_cipher.sv
// start, key letter, other codes and beats answered without a table read load the result
// from the accepted beat; encrypt/decrypt of a letter with a ready key goes through a
// registered table read; finish walks the alphabet, one letter per walk step, or loads the
// result directly when the key has an error. One item is in flight at a time: no beat is
// taken during the table read or the walk
// reset: i_rst_n synchronous active low clears key state and handshake; tables keep contents
`default_nettype none

module keyword_substitution_cipher import kwsc_pkg::*; (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_tvalid,
    output logic             o_s_tready,
    input  wire  [IN_W-1:0]  i_s_tdata,   // action[2:0], char_in[10:3], zero pad
    output logic             o_m_tvalid,
    input  wire              i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata    // char_out[7:0], status[9:8], zero pad
);

    t_cmd  cmd;
    t_stat stat;

    kwsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    kwsc_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (i_s_tdata),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .o_m_tdata (o_m_tdata)
    );

`ifndef SYNTHESIS
    a_no_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while result slot held");

    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.direct, cmd.look_done, cmd.walk_end}))
        else $error("more than one result load");

    a_walk_sets_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.walk_end |=> (stat.key_ready && o_m_tvalid))
        else $error("finish walk did not leave key ready with a result");

    a_look_needs_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.look_done |-> stat.key_ready)
        else $error("table lookup without a ready key");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import kwsc_pkg::*;

    // action codes the block does not define, echoed with status ok
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 1600;
    localparam int MAX_IDLE     = 11;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        t_status           st;
    } t_cipher_out;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;    // action[2:0], char_in[10:3], zero pad
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;          // char_out[7:0], status[9:8], zero pad

    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    int items_sent;
    int mismatch_count;

    // predicted cipher state
    logic [IDX_W-1:0]         fwd_map [ALPHABET_SIZE];
    logic [IDX_W-1:0]         inv_map [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] used_mask = '0;
    int                       fill_cnt;
    bit                       key_ok;
    bit                       key_bad;

    t_cipher_out cipher_out_q[$];

    keyword_substitution_cipher DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic int letter_idx(input logic [CHAR_W-1:0] c);
        if (c >= CH_UPPER_A && c < CH_UPPER_A + ALPHABET_SIZE)
            return c - CH_UPPER_A;
        if (c >= CH_LOWER_A && c < CH_LOWER_A + ALPHABET_SIZE)
            return c - CH_LOWER_A;
        return -1;
    endfunction

    function automatic void place_letter(input int idx);
        if (!used_mask[idx] && fill_cnt < ALPHABET_SIZE) begin
            used_mask[idx]    = 1'b1;
            fwd_map[fill_cnt] = IDX_W'(idx);
            fill_cnt++;
        end
    endfunction

    function automatic void predict_cipher(input logic [ACT_W-1:0] act,
                                           input logic [CHAR_W-1:0] c);
        t_cipher_out       e;
        int                li;
        int                n;
        logic [CHAR_W-1:0] base;
        e.ch = c;
        e.st = STAT_OK;
        li   = letter_idx(c);
        case (act)
            ACT_START: begin
                used_mask = '0;
                fill_cnt  = 0;
                key_ok    = 1'b0;
                key_bad   = 1'b0;
            end
            ACT_LETTER: begin
                if (!key_ok && !key_bad) begin
                    if (li < 0)
                        key_bad = 1'b1;
                    else
                        place_letter(li);
                end
                e.st = key_bad ? STAT_BAD_KEY : STAT_OK;
            end
            ACT_FINISH: begin
                if (key_bad) begin
                    e.st = STAT_BAD_KEY;
                end else begin
                    for (n = 0; n < ALPHABET_SIZE; n++)
                        place_letter(n);
                    for (n = 0; n < ALPHABET_SIZE; n++)
                        inv_map[fwd_map[n]] = IDX_W'(n);
                    key_ok = 1'b1;
                end
            end
            ACT_ENCRYPT, ACT_DECRYPT: begin
                if (!key_ok) begin
                    e.st = STAT_NOT_READY;
                end else if (li >= 0) begin
                    base = (c >= CH_LOWER_A) ? CH_LOWER_A : CH_UPPER_A;
                    e.ch = base + ((act == ACT_ENCRYPT) ? fwd_map[li] : inv_map[li]);
                end
            end
            default: ;
        endcase
        cipher_out_q.push_back(e);
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        $display("mismatch %s: want %h got %h at %0t", what, want, got, $time);
        mismatch_count++;
    endtask

    function automatic logic [CHAR_W-1:0] rand_letter();
        logic [CHAR_W-1:0] base;
        base = $urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A;
        return base + CHAR_W'($urandom_range(0, ALPHABET_SIZE - 1));
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(input logic [ACT_W-1:0] act, input logic [CHAR_W-1:0] c);
        int gap;
        gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - ACT_W - CHAR_W){1'b0}}, c, act};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_cipher(act, c);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (cipher_out_q.size() != 0);
    endtask

    task automatic test_no_key();
        int a;
        send_beat(ACT_ENCRYPT, "A");
        send_beat(ACT_DECRYPT, "z");
        send_beat(ACT_ENCRYPT, 8'h00);
        for (a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++)
            send_beat(ACT_W'(a), 8'hFF);
    endtask

    task automatic test_keyword();
        send_beat(ACT_START, 8'hFF);
        send_beat(ACT_LETTER, "K");
        send_beat(ACT_LETTER, "e");
        send_beat(ACT_LETTER, "y");
        send_beat(ACT_LETTER, "k");     // repeat in other case, skipped
        send_beat(ACT_LETTER, "Z");
        send_beat(ACT_FINISH, 8'h00);
        send_beat(ACT_ENCRYPT, "a");
        send_beat(ACT_ENCRYPT, "Z");
        send_beat(ACT_DECRYPT, "q");
        // bytes just outside the letter ranges
        send_beat(ACT_ENCRYPT, "@");
        send_beat(ACT_ENCRYPT, "[");
        send_beat(ACT_DECRYPT, "{");
        send_beat(ACT_LETTER, "B");     // ignored while ready
        send_beat(ACT_FINISH, 8'h80);   // rebuild of the same tables
        send_beat(ACT_ENCRYPT, "m");
    endtask

    task automatic test_bad_key();
        send_beat(ACT_START, "S");
        send_beat(ACT_LETTER, "a");
        send_beat(ACT_LETTER, 8'h80);
        send_beat(ACT_LETTER, "b");     // after the error, ignored
        send_beat(ACT_FINISH, 8'h00);
        send_beat(ACT_ENCRYPT, "c");
    endtask

    task automatic test_drain_pause();
        send_beat(ACT_START, 8'h00);
        send_beat(ACT_FINISH, 8'h00);
        repeat (5) send_beat(ACT_ENCRYPT, rand_letter());
        wait_drained();
        repeat (5) send_beat(ACT_DECRYPT, rand_letter());
    endtask

    task automatic test_random_rounds();
        int kind;
        int i;
        logic [CHAR_W-1:0] b;
        while (items_sent < RANDOM_ITEMS) begin
            send_idle = $urandom_range(0, 3) != 0;
            recv_idle = $urandom_range(0, 3) != 0;
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                repeat ($urandom_range(1, 8))
                    send_beat(ACT_W'($urandom_range(0, 7)), CHAR_W'($urandom_range(0, 255)));
            end else begin
                // kind 1 keeps the old key, so letters can meet a ready key
                if (kind != 1)
                    send_beat(ACT_START, CHAR_W'($urandom_range(0, 255)));
                for (i = $urandom_range(0, 30); i > 0; i--) begin
                    if ($urandom_range(0, 39) == 0) begin
                        do b = CHAR_W'($urandom_range(0, 255)); while (letter_idx(b) >= 0);
                        send_beat(ACT_LETTER, b);
                    end else begin
                        send_beat(ACT_LETTER, rand_letter());
                    end
                end
                send_beat(ACT_FINISH, CHAR_W'($urandom_range(0, 255)));
                for (i = $urandom_range(1, 30); i > 0; i--) begin
                    b = ($urandom_range(0, 9) < 8) ? rand_letter()
                                                   : CHAR_W'($urandom_range(0, 255));
                    send_beat($urandom_range(0, 1) ? ACT_ENCRYPT : ACT_DECRYPT, b);
                end
            end
            if ($urandom_range(0, 15) == 0)
                wait_drained();
        end
    endtask

    // result side: random stall before each beat
    initial begin
        int stall;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_cipher_out want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (cipher_out_q.size() == 0) begin
                report_mismatch("unexpected result beat", 16'h0, m_tdata);
            end else begin
                want = cipher_out_q.pop_front();
                if (m_tdata[CHAR_W-1:0] !== want.ch)
                    report_mismatch("char_out", 16'(want.ch), 16'(m_tdata[CHAR_W-1:0]));
                if (m_tdata[CHAR_W+STAT_W-1:CHAR_W] !== want.st)
                    report_mismatch("status", 16'(want.st),
                                    16'(m_tdata[CHAR_W+STAT_W-1:CHAR_W]));
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_no_key();
        test_keyword();
        test_bad_key();
        test_drain_pause();
        test_random_rounds();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
